// ----- src/ebf_pkg.sv -----
// Package for the eased brightness fader: fixed field widths, saturation limits,
// command and pattern codes and the sequencer state type. No dependencies.
package ebf_pkg;

   localparam int DUR_W     = 16;
   localparam int LEN_W     = 17;
   localparam int ELAPSED_W = 18;
   localparam int TICK_W    = 10;

   localparam logic [LEN_W-1:0]     FLEN_MAX    = 17'h1FFFF;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 18'h3FFFF;
   localparam logic [TICK_W-1:0]    TICK_RESET  = 10'd20;

   localparam logic [1:0] FUNC_FADE    = 2'd0;
   localparam logic [1:0] FUNC_SET     = 2'd1;
   localparam logic [1:0] FUNC_PATTERN = 2'd2;
   localparam logic [1:0] FUNC_TICK    = 2'd3;

   localparam logic [1:0] PAT_NONE     = 2'd0;
   localparam logic [1:0] PAT_ON_OFF   = 2'd1;
   localparam logic [1:0] PAT_OFF_ON   = 2'd2;
   localparam logic [1:0] PAT_PERIODIC = 2'd3;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_DIV_T  = 7'b0000010,
      S_SQUARE = 7'b0000100,
      S_DEN    = 7'b0001000,
      S_DIV_M  = 7'b0010000,
      S_SCALE  = 7'b0100000,
      S_FINISH = 7'b1000000
   } state_type;

endpackage

// ----- src/eased_brightness_fader_top.sv -----
// Eased brightness fader: top level with the command logic, the sequencer, the shared
// multiplier and the state. Depends on ebf_pkg and ebf_divider.
// Fade, set, pattern, idle and finishing ticks respond in the cycle after the request, and
// such requests may follow back to back while the output is not stalled. A tick that
// advances a running fade makes two divider passes (t, then the ease), or only the ease
// pass when t is already one; no request is taken meanwhile. Reset (synchronous) clears
// the fade and sequencer state, sets the tick period to 20 ms and empties the output.
module eased_brightness_fader_top
   import ebf_pkg::*;
#(
   parameter int LEVEL_BITS    = 12,
   parameter int FRACTION_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_func,
   input  logic signed [LEVEL_BITS+1:0]  req_level,
   input  logic [DUR_W-1:0]              req_duration_ms,
   input  logic                          req_state_on,
   input  logic [1:0]                    req_pattern,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [LEVEL_BITS-1:0]         rsp_brightness,
   output logic                          rsp_status,
   output logic                          rsp_fading,
   output logic                          rsp_fade_done,
   input  logic                          csr_wr_en,
   input  logic [TICK_W-1:0]             csr_wr_data
);

   localparam int L  = LEVEL_BITS;
   localparam int F  = FRACTION_BITS;
   // Divisor width covers both the fade length and the ease denominator.
   localparam int DW = (LEN_W > F + 1) ? LEN_W : F + 1;
   localparam int QW = F + 2;
   localparam int MW = (F + 1 > L + 1) ? F + 1 : L + 1;
   localparam int RW = F + L + 1;

   localparam logic [F:0]      ONE  = {1'b1, {F{1'b0}}};
   localparam logic [RW-1:0]   HALF = RW'(1) << (F - 1);
   localparam logic [L-1:0]    LMAX = '1;

   // Fade state.
   logic [L-1:0]           current_ff, current_in;
   logic signed [L+1:0]    start_ff, start_in;
   logic [L-1:0]           goal_ff, goal_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [ELAPSED_W-1:0]   elapsed_ff, elapsed_in;
   logic                   ticker_ff, ticker_in;
   logic [1:0]             pattern_ff, pattern_in;
   logic [TICK_W-1:0]      tick_period_ff, tick_period_in;

   // Sequencer and datapath registers.
   state_type              state_ff, state_in;
   logic [F:0]             tt_ff, tt_in;
   logic [F:0]             m_ff, m_in;
   logic [2*MW-1:0]        prod_ff, prod_in;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [L-1:0]           rsp_brightness_ff, rsp_brightness_in;
   logic                   rsp_status_ff, rsp_status_in;
   logic                   rsp_fading_ff, rsp_fading_in;
   logic                   rsp_done_ff, rsp_done_in;

   logic out_free;
   logic accept;

   // Command decode results: the state as it stands after this request.
   logic [L-1:0]           cur_c, goal_c;
   logic signed [L+1:0]    start_c;
   logic [LEN_W-1:0]       len_c;
   logic [ELAPSED_W-1:0]   el_c;
   logic                   ticker_c;
   logic [1:0]             pat_c;
   logic                   status_c, done_c, adv_go;
   logic                   fade_go, fading_c;
   logic [L-1:0]           fade_val;
   logic [LEN_W-1:0]       fade_t;
   logic [LEN_W:0]         fade_dbl;
   logic                   lvl_neg, lvl_high;

   // Divider interface.
   logic                   div_start, div_done;
   logic [DW-1:0]          div_rem, div_dvs;
   logic [QW-1:0]          div_low, div_quot;

   // Arithmetic.
   logic [MW-1:0]          mul_a, mul_b;
   logic [2*MW-1:0]        mul_p;
   logic [F:0]             sq;
   logic [F+2:0]           den_w;
   logic signed [L+1:0]    span;
   logic [L:0]             span_mag;
   logic [RW-1:0]          rnd;
   logic [L:0]             step_mag;
   logic signed [L+2:0]    nv;
   logic [L-1:0]           nv_clamped;
   logic [ELAPSED_W:0]     el_sum;
   logic                   need_div;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;

   // Command decode. A fade request from a command or from pattern chaining is applied
   // last, with a retarget that doubles the time when a fade is still running.
   always_comb begin
      cur_c    = current_ff;
      goal_c   = goal_ff;
      start_c  = start_ff;
      len_c    = len_ff;
      el_c     = elapsed_ff;
      ticker_c = ticker_ff;
      pat_c    = pattern_ff;
      status_c = 1'b0;
      done_c   = 1'b0;
      adv_go   = 1'b0;
      fade_go  = 1'b0;
      fade_val = '0;
      fade_t   = '0;
      fade_dbl = '0;
      fading_c = 1'b0;
      lvl_neg  = req_level < 0;
      lvl_high = req_level > $signed({2'b00, LMAX});
      unique case (req_func)
         FUNC_FADE: begin
            if (req_duration_ms == '0) begin
               if (lvl_neg) begin
                  cur_c = '0;
               end else if (lvl_high) begin
                  cur_c = LMAX;
               end else begin
                  cur_c = req_level[L-1:0];
               end
            end else if (lvl_neg || lvl_high) begin
               status_c = 1'b1;
            end else begin
               fade_go  = 1'b1;
               fade_val = req_level[L-1:0];
               fade_t   = LEN_W'(req_duration_ms);
            end
         end
         FUNC_SET: begin
            pat_c    = PAT_NONE;
            ticker_c = 1'b0;
            cur_c    = req_state_on ? LMAX : '0;
         end
         FUNC_PATTERN: begin
            pat_c  = req_pattern;
            fade_t = LEN_W'(req_duration_ms >> 1);
            unique case (req_pattern)
               PAT_ON_OFF: begin
                  fade_go  = 1'b1;
                  fade_val = LMAX;
               end
               PAT_OFF_ON: begin
                  fade_go  = 1'b1;
                  fade_val = '0;
               end
               PAT_PERIODIC: begin
                  fade_go  = 1'b1;
                  fade_val = (current_ff == '0) ? LMAX : '0;
               end
               default: begin
                  fade_go = 1'b0;
               end
            endcase
         end
         default: begin
            if (ticker_ff) begin
               if (goal_ff == current_ff) begin
                  ticker_c = 1'b0;
                  done_c   = 1'b1;
                  fade_t   = len_ff;
                  unique case (pattern_ff)
                     PAT_ON_OFF: begin
                        pat_c    = PAT_NONE;
                        fade_go  = 1'b1;
                        fade_val = '0;
                     end
                     PAT_OFF_ON: begin
                        pat_c    = PAT_NONE;
                        fade_go  = 1'b1;
                        fade_val = LMAX;
                     end
                     PAT_PERIODIC: begin
                        fade_go  = 1'b1;
                        fade_val = (current_ff == '0) ? LMAX : '0;
                     end
                     default: begin
                        fade_go = 1'b0;
                     end
                  endcase
               end else begin
                  adv_go = 1'b1;
               end
            end
         end
      endcase

      // A fade to the current level is ignored once time has started running.
      if (fade_go && ((fade_val != cur_c) || (el_c == '0))) begin
         fading_c = ticker_c && (goal_c != cur_c);
         if (!fading_c) begin
            start_c  = $signed({2'b00, cur_c});
            goal_c   = fade_val;
            len_c    = fade_t;
            el_c     = '0;
            ticker_c = 1'b1;
         end else begin
            fade_dbl = {fade_t, 1'b0};
            len_c    = fade_dbl[LEN_W] ? FLEN_MAX : fade_dbl[LEN_W-1:0];
            el_c     = ELAPSED_W'(fade_t);
            goal_c   = fade_val;
            start_c  = $signed({1'b0, cur_c, 1'b0}) - $signed({2'b00, fade_val});
         end
      end
   end

   // Datapath pieces shared by the sequencer states.
   always_comb begin
      need_div = (len_ff != '0) && ({1'b0, elapsed_ff} < {2'b00, len_ff});
      sq       = prod_ff[2*F:F];
      den_w    = {1'b0, sq, 1'b0} + (F+3)'(ONE) - {1'b0, tt_ff, 1'b0};
      span     = $signed({2'b00, goal_ff}) - start_ff;
      span_mag = span[L+1] ? (L+1)'(0) - span[L:0] : span[L:0];
      mul_a    = (state_ff == S_SQUARE) ? MW'(tt_ff) : MW'(m_ff);
      mul_b    = (state_ff == S_SQUARE) ? MW'(tt_ff) : MW'(span_mag);
      mul_p    = mul_a * mul_b;
      rnd      = prod_ff[RW-1:0] + HALF;
      step_mag = rnd[RW-1:F];
      if (span[L+1]) begin
         nv = $signed({start_ff[L+1], start_ff}) - $signed({2'b00, step_mag});
      end else begin
         nv = $signed({start_ff[L+1], start_ff}) + $signed({2'b00, step_mag});
      end
      if (nv < 0) begin
         nv_clamped = '0;
      end else if (nv > $signed({3'b000, LMAX})) begin
         nv_clamped = LMAX;
      end else begin
         nv_clamped = nv[L-1:0];
      end
      el_sum = {1'b0, elapsed_ff} + (ELAPSED_W+1)'(tick_period_ff);
   end

   // Divider operands: t = elapsed/length first, then ease = square/denominator.
   // Both are fed as a remainder already below the divisor plus the low dividend bits.
   always_comb begin
      div_start = 1'b0;
      div_rem   = DW'(elapsed_ff >> 2);
      div_low   = {elapsed_ff[1:0], {F{1'b0}}};
      div_dvs   = DW'(len_ff);
      if (state_ff == S_DEN) begin
         div_start = 1'b1;
         div_rem   = DW'(sq >> 2);
         div_low   = {sq[1:0], {F{1'b0}}};
         div_dvs   = DW'(den_w);
      end else if (accept && adv_go && need_div) begin
         div_start = 1'b1;
      end
   end

   ebf_divider #(
      .DW (DW),
      .QW (QW)
   ) u_divider (
      .clock      (clock),
      .reset      (reset),
      .start_i    (div_start),
      .rem_init_i (div_rem),
      .low_i      (div_low),
      .divisor_i  (div_dvs),
      .done_o     (div_done),
      .quot_o     (div_quot)
   );

   // Sequencer.
   always_comb begin
      state_in          = state_ff;
      current_in        = current_ff;
      start_in          = start_ff;
      goal_in           = goal_ff;
      len_in            = len_ff;
      elapsed_in        = elapsed_ff;
      ticker_in         = ticker_ff;
      pattern_in        = pattern_ff;
      tick_period_in    = csr_wr_en ? csr_wr_data : tick_period_ff;
      tt_in             = tt_ff;
      m_in              = m_ff;
      prod_in           = prod_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_brightness_in = rsp_brightness_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_fading_in     = rsp_fading_ff;
      rsp_done_in       = rsp_done_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (adv_go) begin
                  if (need_div) begin
                     state_in = S_DIV_T;
                  end else begin
                     tt_in    = ONE;
                     state_in = S_SQUARE;
                  end
               end else begin
                  current_in        = cur_c;
                  start_in          = start_c;
                  goal_in           = goal_c;
                  len_in            = len_c;
                  elapsed_in        = el_c;
                  ticker_in         = ticker_c;
                  pattern_in        = pat_c;
                  rsp_valid_in      = 1'b1;
                  rsp_brightness_in = cur_c;
                  rsp_status_in     = status_c;
                  rsp_fading_in     = ticker_c && (goal_c != cur_c);
                  rsp_done_in       = done_c;
               end
            end
         end
         S_DIV_T: begin
            if (div_done) begin
               tt_in    = div_quot[F:0];
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            prod_in  = mul_p;
            state_in = S_DEN;
         end
         S_DEN: begin
            state_in = S_DIV_M;
         end
         S_DIV_M: begin
            if (div_done) begin
               m_in     = (div_quot > QW'(ONE)) ? ONE : div_quot[F:0];
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            prod_in  = mul_p;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               current_in        = nv_clamped;
               elapsed_in        = el_sum[ELAPSED_W] ? ELAPSED_MAX : el_sum[ELAPSED_W-1:0];
               rsp_valid_in      = 1'b1;
               rsp_brightness_in = nv_clamped;
               rsp_status_in     = 1'b0;
               rsp_fading_in     = ticker_ff && (goal_ff != nv_clamped);
               rsp_done_in       = 1'b0;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         current_ff     <= '0;
         start_ff       <= '0;
         goal_ff        <= '0;
         len_ff         <= '0;
         elapsed_ff     <= '0;
         ticker_ff      <= 1'b0;
         pattern_ff     <= PAT_NONE;
         tick_period_ff <= TICK_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         current_ff     <= current_in;
         start_ff       <= start_in;
         goal_ff        <= goal_in;
         len_ff         <= len_in;
         elapsed_ff     <= elapsed_in;
         ticker_ff      <= ticker_in;
         pattern_ff     <= pattern_in;
         tick_period_ff <= tick_period_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      tt_ff             <= tt_in;
      m_ff              <= m_in;
      prod_ff           <= prod_in;
      rsp_brightness_ff <= rsp_brightness_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_fading_ff     <= rsp_fading_in;
      rsp_done_ff       <= rsp_done_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_brightness = rsp_brightness_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_fading     = rsp_fading_ff;
   assign rsp_fade_done  = rsp_done_ff;

   // No request is taken while the sequencer works on a tick.
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("request accepted while busy");

   // The ease division always starts right after the denominator is formed.
   a_den_to_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DEN) |=> (state_ff == S_DIV_M))
      else $error("ease division not started");

   // A rejected fade never reports a finished fade.
   a_status_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> !rsp_fade_done)
      else $error("reject and done together");

   // A tick sent to the arithmetic path only runs while a fade is running.
   a_tick_fading: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQUARE) |-> (ticker_ff && (goal_ff != current_ff)))
      else $error("advance without a running fade");

endmodule

// ----- src/ebf_divider.sv -----
// Shared restoring divider of the eased brightness fader, one quotient bit per cycle.
// Depends on nothing but its parameters.
module ebf_divider #(
   parameter int DW = 17,
   parameter int QW = 18
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start_i,
   input  logic [DW-1:0] rem_init_i,
   input  logic [QW-1:0] low_i,
   input  logic [DW-1:0] divisor_i,
   output logic          done_o,
   output logic [QW-1:0] quot_o
);

   localparam int CW = $clog2(QW + 1);

   logic [DW-1:0] rem_ff, rem_in;
   logic [QW-1:0] low_ff, low_in;
   logic [DW-1:0] dvs_ff, dvs_in;
   logic [QW-1:0] quot_ff, quot_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;

   logic [DW:0] trial;
   logic [DW:0] diff;
   logic        fits;

   // The caller guarantees that the initial remainder is below the divisor.
   always_comb begin
      trial = {rem_ff, low_ff[QW-1]};
      fits  = trial >= {1'b0, dvs_ff};
      diff  = trial - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      low_in  = low_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start_i) begin
         rem_in  = rem_init_i;
         low_in  = low_i;
         dvs_in  = divisor_i;
         quot_in = '0;
         cnt_in  = CW'(QW);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? diff[DW-1:0] : trial[DW-1:0];
         low_in  = {low_ff[QW-2:0], 1'b0};
         quot_in = {quot_ff[QW-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
   end

   assign done_o = done_ff;
   assign quot_o = quot_ff;

endmodule
